// ----- rtl/llgd_pkg.sv -----
// Shared constants, types and helpers for the least-loaded gate dispatcher.
package llgd_pkg;

    localparam int GATES       = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int GATE_IDX_W  = (GATES > 1) ? $clog2(GATES) : 1;

    localparam int ACTIVE_W = 5;
    localparam int PEOPLE_W = 8;
    localparam int GROUP_W  = 8;
    localparam int GINDEX_W = 4;
    localparam int GNUM_W   = 5;
    localparam int GCOUNT_W = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [GATE_IDX_W-1:0]  gate_idx_t;

    typedef enum logic
    {
        OP_ASSIGN  = 1'b0,
        OP_ADD_ONE = 1'b1
    } llgd_op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_INC_RD,
        S_INC_WR,
        S_PEEK,
        S_PEEK_DATA,
        S_DONE
    } seq_state_t;

    typedef struct packed
    {
        logic      rd_en;
        gate_idx_t rd_addr;
        logic      wr_en;
        gate_idx_t wr_addr;
        count_t    wr_data;
    } mem_req_t;

    typedef struct packed
    {
        logic [GNUM_W-1:0]   gate_number;
        logic [GCOUNT_W-1:0] gate_count;
        logic                saturated;
    } result_t;

    // Saturating add; the top bit flags a clip.
    function automatic logic [COUNT_WIDTH:0] sat_add(count_t a, logic [GROUP_W-1:0] inc);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + (COUNT_WIDTH+1)'(inc);
        if (s[COUNT_WIDTH])
        begin
            s = {1'b1, {COUNT_WIDTH{1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [GNUM_W-1:0] idx_to_number(gate_idx_t idx);
        return GNUM_W'(GNUM_W'(idx) + GNUM_W'(1));
    endfunction

endpackage

// ----- rtl/llgd_cnt_ram.sv -----
// Gate counter memory: one write and one registered read port, valid bit per entry.
module llgd_cnt_ram
    import llgd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t mem_req,
    output count_t   rd_data
);

    count_t             mem [GATES];
    logic [GATES-1:0]   valid_reg;
    count_t             rd_data_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                valid_reg[mem_req.wr_addr] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                rd_vld_reg <= valid_reg[mem_req.rd_addr];
            end
        end
    end

    // an entry never written reads as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/llgd_seq.sv -----
// Dispatch sequencer: scans gate counters through the memory and updates the pick.
module llgd_seq
    import llgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [0:0]          opcode,
    input  logic [PEOPLE_W-1:0] people,
    input  logic [GROUP_W-1:0]  group_size,
    input  logic [GINDEX_W-1:0] gate_index,
    input  logic [ACTIVE_W-1:0] active_gates,
    output logic                busy,
    output mem_req_t            mem_req,
    input  count_t              rd_data,
    output logic                res_valid,
    input  logic                res_take,
    output result_t             res
);

    seq_state_t          state_reg, state_next;
    gate_idx_t           g_reg, g_next;
    gate_idx_t           last_reg, last_next;
    logic [PEOPLE_W-1:0] rounds_reg, rounds_next;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic [GINDEX_W-1:0] gidx_reg, gidx_next;
    count_t              best_reg, best_next;
    gate_idx_t           pick_reg, pick_next;
    logic                clip_reg, clip_next;
    logic                rd_pend_reg, rd_pend_next;
    gate_idx_t           rd_idx_reg, rd_idx_next;
    result_t             res_reg, res_next;

    logic                 accept;
    logic                 gidx_ok;
    logic [GROUP_W-1:0]   inc;
    logic [COUNT_WIDTH:0] sum;
    logic [COUNT_WIDTH:0] inc_sum;

    assign accept  = req_valid && (state_reg == S_IDLE);
    assign gidx_ok = (int'(gidx_reg) < GATES);
    assign inc     = (group_reg == '0) ? GROUP_W'(1) : group_reg;
    assign sum     = sat_add(best_next, inc);
    assign inc_sum = sat_add(rd_data, GROUP_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ADD_ONE)
                    begin
                        state_next = S_INC_RD;
                    end
                    else if (people == '0)
                    begin
                        state_next = S_PEEK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (g_reg == last_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = (rounds_reg == PEOPLE_W'(1)) ? S_DONE : S_SCAN;
            end
            S_INC_RD:    state_next = S_INC_WR;
            S_INC_WR:    state_next = S_DONE;
            S_PEEK:      state_next = S_PEEK_DATA;
            S_PEEK_DATA: state_next = S_DONE;
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        mem_req   = '0;
        busy      = (state_reg != S_IDLE);
        res_valid = (state_reg == S_DONE);
        case (state_reg)
            S_SCAN:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = g_reg;
            end
            S_WRITE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pick_next;
                mem_req.wr_data = sum[COUNT_WIDTH-1:0];
            end
            S_INC_RD:
            begin
                mem_req.rd_en   = gidx_ok;
                mem_req.rd_addr = GATE_IDX_W'(gidx_reg);
            end
            S_INC_WR:
            begin
                mem_req.wr_en   = gidx_ok;
                mem_req.wr_addr = GATE_IDX_W'(gidx_reg);
                mem_req.wr_data = inc_sum[COUNT_WIDTH-1:0];
            end
            S_PEEK:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        g_next       = g_reg;
        last_next    = last_reg;
        rounds_next  = rounds_reg;
        group_next   = group_reg;
        gidx_next    = gidx_reg;
        clip_next    = clip_reg;
        res_next     = res_reg;
        rd_pend_next = (state_reg == S_SCAN);
        rd_idx_next  = g_reg;

        // running minimum; ties move to the later gate
        best_next = best_reg;
        pick_next = pick_reg;
        if (rd_pend_reg && ((rd_idx_reg == '0) || (rd_data <= best_reg)))
        begin
            best_next = rd_data;
            pick_next = rd_idx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rounds_next = people;
                    group_next  = group_size;
                    gidx_next   = gate_index;
                    clip_next   = 1'b0;
                    g_next      = '0;
                    if (active_gates == '0)
                    begin
                        last_next = '0;
                    end
                    else if (int'(active_gates) > GATES)
                    begin
                        last_next = GATE_IDX_W'(GATES - 1);
                    end
                    else
                    begin
                        last_next = GATE_IDX_W'(active_gates - ACTIVE_W'(1));
                    end
                end
            end
            S_SCAN:
            begin
                g_next = gate_idx_t'(g_reg + gate_idx_t'(1));
            end
            S_WRITE:
            begin
                g_next      = '0;
                rounds_next = rounds_reg - PEOPLE_W'(1);
                clip_next   = clip_reg | sum[COUNT_WIDTH];
                res_next.gate_number = idx_to_number(pick_next);
                res_next.gate_count  = GCOUNT_W'(sum[COUNT_WIDTH-1:0]);
                res_next.saturated   = clip_reg | sum[COUNT_WIDTH];
            end
            S_INC_WR:
            begin
                res_next.gate_number = GNUM_W'(GNUM_W'(gidx_reg) + GNUM_W'(1));
                if (gidx_ok)
                begin
                    res_next.gate_count = GCOUNT_W'(inc_sum[COUNT_WIDTH-1:0]);
                    res_next.saturated  = inc_sum[COUNT_WIDTH];
                end
                else
                begin
                    res_next.gate_count = '0;
                    res_next.saturated  = 1'b0;
                end
            end
            S_PEEK_DATA:
            begin
                res_next.gate_number = GNUM_W'(1);
                res_next.gate_count  = GCOUNT_W'(rd_data);
                res_next.saturated   = 1'b0;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg      <= g_next;
        last_reg   <= last_next;
        rounds_reg <= rounds_next;
        group_reg  <= group_next;
        gidx_reg   <= gidx_next;
        best_reg   <= best_next;
        pick_reg   <= pick_next;
        clip_reg   <= clip_next;
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- rtl/least_loaded_gate_dispatcher_unit.sv -----
// Top level of the least-loaded gate dispatcher: config register, sequencer, memory, result stage.
//
// Usage:
//   Request channel (req_valid / req_stall) carries opcode, people, group_size and
//   gate_index; a transfer happens on a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) carries gate_number, gate_count and
//   saturated; every request produces exactly one response transfer.
//   cfg_we / cfg_wdata write active_gates; write only while no request is in flight.
// Operation (one request at a time):
//   add-one (opcode 1) steps through INC_RD and INC_WR, people = 0 through PEEK
//   and PEEK_DATA, and the result then enters the response register.
//   assign: people rounds, each a scan and a write. The gate counters sit in a
//   single memory with one read port, so each round reads every active gate once,
//   one per cycle, then writes the chosen gate back.
//   The next request can transfer in the cycle after the result enters the output register.
// Reset: asynchronous, active low. All gate counters read as zero afterward (a valid
//   bit per entry) and active_gates returns to 16. No clearing pass is needed.
// Stall: the response sits in an output register; the next request is taken while a
//   finished response waits, and its own result holds in the sequencer until the
//   output register frees up.
module least_loaded_gate_dispatcher_unit
    import llgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    output logic                req_stall,
    input  logic [0:0]          opcode,
    input  logic [PEOPLE_W-1:0] people,
    input  logic [GROUP_W-1:0]  group_size,
    input  logic [GINDEX_W-1:0] gate_index,

    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [GNUM_W-1:0]   gate_number,
    output logic [GCOUNT_W-1:0] gate_count,
    output logic                saturated,

    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_wdata
);

    logic [ACTIVE_W-1:0] active_gates_reg;

    logic     busy;
    mem_req_t mem_req;
    count_t   rd_data;
    logic     res_valid;
    logic     res_take;
    result_t  res;

    logic     rsp_valid_reg, rsp_valid_next;
    result_t  rsp_reg, rsp_next;

    // Hold the gate count register; the user must write it only between requests, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_gates_reg <= ACTIVE_W'(16);
        end
        else if (cfg_we)
        begin
            active_gates_reg <= cfg_wdata;
        end
    end

    llgd_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .opcode       (opcode),
        .people       (people),
        .group_size   (group_size),
        .gate_index   (gate_index),
        .active_gates (active_gates_reg),
        .busy         (busy),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    llgd_cnt_ram u_cnt_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign req_stall = busy;

    // Advance the result into the output register when it is empty or draining.
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            // drop valid once the transfer completes
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign gate_number = rsp_reg.gate_number;
    assign gate_count  = rsp_reg.gate_count;
    assign saturated   = rsp_reg.saturated;

    // The sequencer never reads and writes the same counter in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en && (mem_req.rd_addr == mem_req.wr_addr)))
        else $error("counter read and write collide on one entry");

    // A request transfer always leaves the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("block not busy after request transfer");

    // Counters change only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> busy)
        else $error("counter write while idle");

    // A result that moves to the output register always raises rsp_valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (rsp_valid && !busy) || (rsp_valid && busy && $past(req_valid)) ||
                      rsp_valid)
        else $error("result transfer lost");

endmodule

// ----- bench/gate_dispatch_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the least-loaded gate dispatcher: gate occupancy predictor and compare.
module gate_dispatch_checker
    import llgd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    input  logic                req_stall,
    input  logic [0:0]          opcode,
    input  logic [PEOPLE_W-1:0] people,
    input  logic [GROUP_W-1:0]  group_size,
    input  logic [GINDEX_W-1:0] gate_index,

    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [GNUM_W-1:0]   gate_number,
    input  logic [GCOUNT_W-1:0] gate_count,
    input  logic                saturated,

    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_wdata,

    output int                  outstanding,
    output int                  fail_count
);

    localparam count_t COUNT_MAX = '1;

    count_t              occupancy [GATES];
    logic [ACTIVE_W-1:0] active_gates;
    result_t             expected_gates [$];
    result_t             want;
    int                  errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(string msg);
        errors++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Update the occupancy copy for one transfer and return the response it should produce.
    function automatic result_t dispatch_people(llgd_op_t op, logic [PEOPLE_W-1:0] ppl,
                                                logic [GROUP_W-1:0] grp,
                                                logic [GINDEX_W-1:0] gidx);
        int unsigned          live;
        int unsigned          pick;
        int unsigned          g;
        count_t               best;
        logic [COUNT_WIDTH:0] sum;
        logic [COUNT_WIDTH:0] step;
        result_t              r;

        r.saturated = 1'b0;
        live = 32'(active_gates);
        if (live < 1)
        begin
            live = 1;
        end
        if (live > GATES)
        begin
            live = GATES;
        end

        if (op == OP_ADD_ONE)
        begin
            r.gate_number = GNUM_W'(gidx) + GNUM_W'(1);
            if (int'(gidx) < GATES)
            begin
                sum = {1'b0, occupancy[gidx]} + (COUNT_WIDTH+1)'(1);
                if (sum[COUNT_WIDTH])
                begin
                    occupancy[gidx] = COUNT_MAX;
                    r.saturated = 1'b1;
                end
                else
                begin
                    occupancy[gidx] = sum[COUNT_WIDTH-1:0];
                end
                r.gate_count = GCOUNT_W'(occupancy[gidx]);
            end
            else
            begin
                r.gate_count = '0;
            end
        end
        else
        begin
            pick = 0;
            step = (grp == '0) ? (COUNT_WIDTH+1)'(1) : (COUNT_WIDTH+1)'(grp);
            repeat (ppl)
            begin
                // Scan upward; "<=" lets the highest index win a tie.
                best = occupancy[0];
                for (g = 0; g < live; g++)
                begin
                    if (occupancy[g] <= best)
                    begin
                        best = occupancy[g];
                        pick = g;
                    end
                end
                sum = {1'b0, occupancy[pick]} + step;
                if (sum[COUNT_WIDTH])
                begin
                    occupancy[pick] = COUNT_MAX;
                    r.saturated = 1'b1;
                end
                else
                begin
                    occupancy[pick] = sum[COUNT_WIDTH-1:0];
                end
            end
            r.gate_number = GNUM_W'(pick + 1);
            r.gate_count = GCOUNT_W'(occupancy[pick]);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (occupancy[g])
            begin
                occupancy[g] = '0;
            end
            active_gates <= ACTIVE_W'(GATES);
            expected_gates.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_gates <= cfg_wdata;
            end

            // Check the response first so it never pairs with a request of the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_gates.size() == 0)
                begin
                    report_mismatch($sformatf("response with nothing expected (gate %0d count %0d)",
                                              gate_number, gate_count));
                end
                else
                begin
                    want = expected_gates.pop_front();
                    if (gate_number !== want.gate_number)
                    begin
                        report_mismatch($sformatf("gate_number got %0d want %0d",
                                                  gate_number, want.gate_number));
                    end
                    if (gate_count !== want.gate_count)
                    begin
                        report_mismatch($sformatf("gate_count got %0d want %0d (gate %0d)",
                                                  gate_count, want.gate_count, want.gate_number));
                    end
                    if (saturated !== want.saturated)
                    begin
                        report_mismatch($sformatf("saturated got %0b want %0b (gate %0d)",
                                                  saturated, want.saturated, want.gate_number));
                    end
                end
            end

            if (req_valid && !req_stall)
            begin
                expected_gates.push_back(dispatch_people(llgd_op_t'(opcode), people,
                                                         group_size, gate_index));
            end

            outstanding <= expected_gates.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the least-loaded gate dispatcher regression: clock, reset, stimulus and verdict.
module testbench;
    import llgd_pkg::*;

    // Random part length and how often active_gates changes.
    localparam int RANDOM_ITEMS  = 1750;
    localparam int PHASE_ITEMS   = 160;
    localparam int PHASES        = 11;
    // Window of random items run with no idling on either side.
    localparam int STEADY_FIRST  = 700;
    localparam int STEADY_LAST   = 1000;
    // Percent of cycles each side idles.
    localparam int IDLE_PCT      = 21;
    // Slowest legal item: 255 rounds over 16 gates, plus response stalls; take
    // that several times over.
    localparam int IDLE_LIMIT    = 20000;
    // Cycles to let the block settle before a register write and at the end.
    localparam int CFG_SETTLE    = 4;
    localparam int END_SETTLE    = 20;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;

    logic                req_valid  = 1'b0;
    logic                req_stall;
    logic [0:0]          opcode     = '0;
    logic [PEOPLE_W-1:0] people     = '0;
    logic [GROUP_W-1:0]  group_size = '0;
    logic [GINDEX_W-1:0] gate_index = '0;

    logic                rsp_valid;
    logic                rsp_stall  = 1'b0;
    logic [GNUM_W-1:0]   gate_number;
    logic [GCOUNT_W-1:0] gate_count;
    logic                saturated;

    logic                cfg_we     = 1'b0;
    logic [ACTIVE_W-1:0] cfg_wdata  = '0;

    // High while both sides run without idling.
    logic                steady     = 1'b0;

    int                  outstanding;
    int                  fail_count;
    int                  quiet_cycles = 0;

    // active_gates for each random phase: out-of-range low (0), the minimum,
    // the maximum, above GATES (17..31) and values in between.
    logic [ACTIVE_W-1:0] phase_gates [PHASES] = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd9, 5'd0,
                                                  5'd16, 5'd3, 5'd12, 5'd20, 5'd16};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    least_loaded_gate_dispatcher_unit u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .people      (people),
        .group_size  (group_size),
        .gate_index  (gate_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .gate_number (gate_number),
        .gate_count  (gate_count),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    gate_dispatch_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .people      (people),
        .group_size  (group_size),
        .gate_index  (gate_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .gate_number (gate_number),
        .gate_count  (gate_count),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Receiver side: stall at random, except inside the steady window.
    always @(posedge clk)
    begin
        rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: end the run once nothing has transferred on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request and hold it until the transfer edge. Idle cycles
    // drop valid first; without them valid stays high from the previous
    // transfer, so it is never lowered and raised within one step.
    task automatic send_item(llgd_op_t op, logic [PEOPLE_W-1:0] ppl,
                             logic [GROUP_W-1:0] grp, logic [GINDEX_W-1:0] gidx);
        while (!steady && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        opcode     <= op;
        people     <= ppl;
        group_size <= grp;
        gate_index <= gidx;
        // Values read right after the edge are the ones that edge sampled.
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
    endtask

    // Drop valid and hold until every expected response has transferred.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    // Write active_gates only with the block idle.
    task automatic write_active_gates(logic [ACTIVE_W-1:0] value);
        drain_responses();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly short assign items with small groups, so counters fill slowly;
    // a few carry the widest people and group values.
    task automatic random_item();
        llgd_op_t            op;
        logic [PEOPLE_W-1:0] ppl;
        logic [GROUP_W-1:0]  grp;
        int unsigned         roll;

        op = ($urandom_range(0, 99) < 30) ? OP_ADD_ONE : OP_ASSIGN;

        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            ppl = '0;
        end
        else if (roll < 13)
        begin
            ppl = PEOPLE_W'($urandom_range(100, 255));
        end
        else
        begin
            ppl = PEOPLE_W'($urandom_range(1, 8));
        end

        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            grp = '0;
        end
        else if (roll < 80)
        begin
            grp = GROUP_W'($urandom_range(1, 4));
        end
        else if (roll < 95)
        begin
            grp = GROUP_W'($urandom_range(5, 40));
        end
        else
        begin
            grp = GROUP_W'($urandom_range(41, 255));
        end

        send_item(op, ppl, grp, GINDEX_W'($urandom_range(0, 15)));
    endtask

    initial
    begin
        int n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset value of active_gates (all 16 gates).
        // No people: gate 1 with its count, nothing changes.
        send_item(OP_ASSIGN, 8'd0, 8'd7, 4'd3);
        // All counters equal: the tie goes to the highest gate; group 0 adds one.
        send_item(OP_ASSIGN, 8'd1, 8'd0, 4'd0);
        send_item(OP_ADD_ONE, 8'd0, 8'd0, 4'd0);
        send_item(OP_ADD_ONE, 8'd255, 8'd255, 4'd15);
        send_item(OP_ADD_ONE, 8'd1, 8'd1, 4'd7);
        send_item(OP_ASSIGN, 8'd3, 8'd255, 4'd0);

        // Zero active gates acts as one; an add-one still reaches an inactive gate.
        write_active_gates(5'd0);
        send_item(OP_ASSIGN, 8'd2, 8'd1, 4'd12);
        send_item(OP_ADD_ONE, 8'd0, 8'd0, 4'd9);

        // One gate: drive gate 1 into saturation with the widest items.
        write_active_gates(5'd1);
        send_item(OP_ASSIGN, 8'd255, 8'd255, 4'd15);
        send_item(OP_ASSIGN, 8'd255, 8'd255, 4'd0);
        send_item(OP_ADD_ONE, 8'd0, 8'd0, 4'd0);
        send_item(OP_ASSIGN, 8'd0, 8'd0, 4'd0);

        // Above the gate count acts as all 16 gates.
        write_active_gates(5'd31);
        send_item(OP_ASSIGN, 8'd20, 8'd0, 4'd5);
        send_item(OP_ASSIGN, 8'd128, 8'd128, 4'd10);

        write_active_gates(5'd17);
        send_item(OP_ASSIGN, 8'd5, 8'd3, 4'd0);

        write_active_gates(5'd2);
        send_item(OP_ASSIGN, 8'd4, 8'd2, 4'd15);
        send_item(OP_ADD_ONE, 8'd0, 8'd0, 4'd10);
        send_item(OP_ADD_ONE, 8'd0, 8'd0, 4'd5);

        // Random part, one active_gates setting per phase.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ((n % PHASE_ITEMS) == 0)
            begin
                write_active_gates(phase_gates[n / PHASE_ITEMS]);
            end
            steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
            // Now and then hold off until the block has emptied.
            if ($urandom_range(0, 99) == 0)
            begin
                drain_responses();
            end
            random_item();
        end

        drain_responses();
        repeat (END_SETTLE) @(posedge clk);

        if ((fail_count == 0) && (outstanding == 0))
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
